// ===== rtl/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg : shared types and constants of the touch contact table
// Operation codes, field widths and the request word broadcast to every cell.
// ----------------------------------------------------------------------------
package tct_pkg;

    // Field widths of one request and one result
    localparam int ID_BITS    = 8;
    localparam int COORD_BITS = 16;
    localparam int OP_BITS    = 3;
    localparam int ACTIVE_W   = 5;

    // Operation codes; codes five to seven behave as a query
    typedef enum logic [OP_BITS-1:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_MOVE    = 3'd2,
        OP_QUERY   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    // Request broadcast along the row of cells
    typedef struct packed {
        logic                         fire;
        t_op                          op;
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_cmd;

endpackage

// ===== rtl/tct_cell.sv =====
// ----------------------------------------------------------------------------
// tct_cell : one entry of the contact table
// Holds id and position, matches the broadcast id, takes over its upper
// neighbour's entry when a release closes a gap below or at this cell.
// ----------------------------------------------------------------------------
module tct_cell (
    input  logic                                 i_clk,
    input  tct_pkg::t_cmd                        i_cmd,
    input  logic                                 i_valid,   // entry below fill count
    input  logic                                 i_tail,    // first free entry
    input  logic                                 i_hit,     // match in a lower cell
    input  logic [tct_pkg::ID_BITS-1:0]          i_nb_id,
    input  logic signed [tct_pkg::COORD_BITS-1:0] i_nb_x,
    input  logic signed [tct_pkg::COORD_BITS-1:0] i_nb_y,
    output logic                                 o_hit,     // match here or below
    output logic                                 o_match,
    output logic [tct_pkg::ID_BITS-1:0]          o_id,
    output logic signed [tct_pkg::COORD_BITS-1:0] o_x,
    output logic signed [tct_pkg::COORD_BITS-1:0] o_y,
    output logic signed [tct_pkg::COORD_BITS-1:0] o_rd_x,    // x when matched, else 0
    output logic signed [tct_pkg::COORD_BITS-1:0] o_rd_y
);
    import tct_pkg::*;

    logic [ID_BITS-1:0]           r_id;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic [ID_BITS-1:0]           n_id;
    logic signed [COORD_BITS-1:0] n_x;
    logic signed [COORD_BITS-1:0] n_y;

    // Id compare and running hit chain
    assign o_match = i_valid && (r_id == i_cmd.id);
    assign o_hit   = i_hit || o_match;

    // Entry update
    always_comb begin
        n_id = r_id;
        n_x  = r_x;
        n_y  = r_y;
        if (i_cmd.fire) begin
            case (i_cmd.op)
                OP_PRESS: begin
                    if (o_match) begin
                        n_x = i_cmd.x;
                        n_y = i_cmd.y;
                    end else if (i_tail && !i_hit) begin
                        // new contact appended at the tail
                        n_id = i_cmd.id;
                        n_x  = i_cmd.x;
                        n_y  = i_cmd.y;
                    end
                end
                OP_RELEASE: begin
                    if (o_hit) begin
                        n_id = i_nb_id;
                        n_x  = i_nb_x;
                        n_y  = i_nb_y;
                    end
                end
                OP_MOVE: begin
                    if (o_match) begin
                        n_x = i_cmd.x;
                        n_y = i_cmd.y;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_x  <= n_x;
        r_y  <= n_y;
    end

    assign o_id   = r_id;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_rd_x = o_match ? r_x : '0;
    assign o_rd_y = o_match ? r_y : '0;

endmodule

// ===== rtl/touch_contact_table_top.sv =====
// ----------------------------------------------------------------------------
// touch_contact_table_top : ordered table of active touch contacts
// Row of entry cells with a fill count and a registered result stage.
// ----------------------------------------------------------------------------
// Each request is taken and its result is held in an output register, so one
// request per cycle is sustained while the result side is ready, and a result
// appears in the cycle after its request is accepted. That rate is set by the
// combinational id compare across all cells and the hit chain that runs
// from the lowest cell to the highest. A release makes every cell at or
// above the match take its upper neighbour's entry in the same cycle, so
// order is kept. Request tuser carries the op code; result tuser carries
// found, duplicate press and full drop. Stored entries need no clearing
// after reset: the fill count alone tells which cells are live.
module touch_contact_table_top #(
    parameter int MAX_CONTACTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // touch_id[7:0], x_in[23:8], y_in[39:24]
    input  logic [tct_pkg::OP_BITS-1:0] s_axis_tuser, // op[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // x_out[15:0], y_out[31:16],
                                                // active_count[36:32], zero[39:37]
    output logic [2:0]          m_axis_tuser    // found[0], duplicate_press[1],
                                                // full_drop[2]
);
    import tct_pkg::*;

    localparam int CW = $clog2(MAX_CONTACTS + 1);

    t_cmd                         w_cmd;
    logic [MAX_CONTACTS:0]        w_hit;
    logic [MAX_CONTACTS-1:0]      w_match;
    logic [ID_BITS-1:0]           w_id   [MAX_CONTACTS];
    logic signed [COORD_BITS-1:0] w_x    [MAX_CONTACTS];
    logic signed [COORD_BITS-1:0] w_y    [MAX_CONTACTS];
    logic signed [COORD_BITS-1:0] w_rd_x [MAX_CONTACTS];
    logic signed [COORD_BITS-1:0] w_rd_y [MAX_CONTACTS];
    logic signed [COORD_BITS-1:0] w_sel_x;
    logic signed [COORD_BITS-1:0] w_sel_y;
    logic                         w_found;
    logic                         w_full;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_out_valid;
    logic                         r_found;
    logic                         r_dup;
    logic                         r_drop;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic [ACTIVE_W-1:0]          r_active;
    logic                         n_dup;
    logic                         n_drop;
    logic signed [COORD_BITS-1:0] n_x;
    logic signed [COORD_BITS-1:0] n_y;

    // Request handshake: take a request whenever the result slot frees
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    assign w_cmd.fire = s_axis_tvalid && s_axis_tready;
    assign w_cmd.op   = t_op'(s_axis_tuser);
    assign w_cmd.id   = s_axis_tdata[ID_BITS-1:0];
    assign w_cmd.x    = s_axis_tdata[ID_BITS +: COORD_BITS];
    assign w_cmd.y    = s_axis_tdata[ID_BITS+COORD_BITS +: COORD_BITS];

    // Row of cells
    assign w_hit[0] = 1'b0;
    for (genvar gi = 0; gi < MAX_CONTACTS; gi++) begin : g_cell
        logic [ID_BITS-1:0]           w_nb_id;
        logic signed [COORD_BITS-1:0] w_nb_x;
        logic signed [COORD_BITS-1:0] w_nb_y;

        if (gi == MAX_CONTACTS - 1) begin : g_last
            assign w_nb_id = w_id[gi];
            assign w_nb_x  = w_x[gi];
            assign w_nb_y  = w_y[gi];
        end else begin : g_mid
            assign w_nb_id = w_id[gi+1];
            assign w_nb_x  = w_x[gi+1];
            assign w_nb_y  = w_y[gi+1];
        end

        tct_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_valid (CW'(gi) < r_count),
            .i_tail  (CW'(gi) == r_count),
            .i_hit   (w_hit[gi]),
            .i_nb_id (w_nb_id),
            .i_nb_x  (w_nb_x),
            .i_nb_y  (w_nb_y),
            .o_hit   (w_hit[gi+1]),
            .o_match (w_match[gi]),
            .o_id    (w_id[gi]),
            .o_x     (w_x[gi]),
            .o_y     (w_y[gi]),
            .o_rd_x  (w_rd_x[gi]),
            .o_rd_y  (w_rd_y[gi])
        );
    end

    assign w_found = w_hit[MAX_CONTACTS];
    assign w_full  = (r_count == CW'(MAX_CONTACTS));

    // Stored position of the matching cell (at most one matches)
    always_comb begin
        w_sel_x = '0;
        w_sel_y = '0;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            w_sel_x = w_sel_x | w_rd_x[i];
            w_sel_y = w_sel_y | w_rd_y[i];
        end
    end

    // Fill count and result fields
    always_comb begin
        n_count = r_count;
        n_dup   = 1'b0;
        n_drop  = 1'b0;
        n_x     = '0;
        n_y     = '0;
        case (w_cmd.op)
            OP_PRESS: begin
                if (w_found) begin
                    n_dup = 1'b1;
                    n_x   = w_cmd.x;
                    n_y   = w_cmd.y;
                end else if (w_full) begin
                    n_drop = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                    n_x     = w_cmd.x;
                    n_y     = w_cmd.y;
                end
            end
            OP_RELEASE: begin
                if (w_found) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_MOVE: begin
                if (w_found) begin
                    n_x = w_cmd.x;
                    n_y = w_cmd.y;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // query and unused codes only report
                n_x = w_sel_x;
                n_y = w_sel_y;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cmd.fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_cmd.fire) begin
            r_found  <= w_found;
            r_dup    <= n_dup;
            r_drop   <= n_drop;
            r_x      <= n_x;
            r_y      <= n_y;
            r_active <= ACTIVE_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_active, r_y, r_x};
    assign m_axis_tuser  = {r_drop, r_dup, r_found};

`ifndef ASSERT_OFF
    // Fill count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CONTACTS))
        else $error("fill count above table size");

    // Live ids are unique, so at most one cell matches
    a_unique_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("id stored in more than one cell");

    // A result is never both a duplicate press and a full drop
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_dup && r_drop))
        else $error("duplicate and full drop flagged together");

    // A clear empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.fire && (w_cmd.op == OP_CLEAR)) |=> (r_count == '0))
        else $error("table not empty after clear");
`endif

endmodule
